// ----- rtl/core/fwr_pkg.sv -----
// ----------------------------------------------------------------------------
// fwr_pkg: shared types and codes
// Operation and status codes, entry layout and control bundle for the
// process queue with delete by id.
// ----------------------------------------------------------------------------
`default_nettype none

package fwr_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned OpWidth       = 2;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned PriorityWidth = 8;
  localparam int unsigned IdWidth       = 22;
  localparam int unsigned RuntimeWidth  = 16;

  localparam logic [OpWidth-1:0] OP_PUSH   = 2'd0;
  localparam logic [OpWidth-1:0] OP_POP    = 2'd1;
  localparam logic [OpWidth-1:0] OP_DELETE = 2'd2;

  localparam logic [StatusWidth-1:0] ST_DONE     = 2'd0;
  localparam logic [StatusWidth-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [PriorityWidth-1:0] priority_val;
    logic [IdWidth-1:0]       id;
    logic [RuntimeWidth-1:0]  runtime;
  } entry_t;

  typedef struct packed {
    logic               push;
    logic               remove;
    logic [IdWidth-1:0] key;
    entry_t             wdata;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/fwr_req_if.sv -----
// ----------------------------------------------------------------------------
// fwr_req_if: request channel
// Valid/ready channel carrying one queue request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwr_req_if;
  logic                                valid;
  logic                                ready;
  logic [fwr_pkg::OpWidth-1:0]         operation;
  logic [fwr_pkg::PriorityWidth-1:0]   priority_in;
  logic [fwr_pkg::IdWidth-1:0]         id_in;
  logic [fwr_pkg::RuntimeWidth-1:0]    runtime_in;

  modport source (output valid, operation, priority_in, id_in, runtime_in, input ready);
  modport sink   (input valid, operation, priority_in, id_in, runtime_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fwr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fwr_rsp_if: response channel
// Valid/ready channel carrying one queue result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [fwr_pkg::StatusWidth-1:0]     status;
  logic [fwr_pkg::PriorityWidth-1:0]   priority_out;
  logic [fwr_pkg::IdWidth-1:0]         id_out;
  logic [fwr_pkg::RuntimeWidth-1:0]    runtime_out;

  modport source (output valid, status, priority_out, id_out, runtime_out, input ready);
  modport sink   (input valid, status, priority_out, id_out, runtime_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fwr_cell.sv -----
// ----------------------------------------------------------------------------
// fwr_cell: one queue slot
// Holds one entry and its valid bit, compares its id against the key,
// ripples the first-match flag and data, and shifts from its successor.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fwr_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic                 prev_valid_i,
  input  wire logic                 next_valid_i,
  input  wire fwr_pkg::entry_t      next_entry_i,
  input  wire logic                 hit_i,
  input  wire fwr_pkg::entry_t      sel_i,
  output logic                      hit_o,
  output fwr_pkg::entry_t           sel_o,
  output logic                      valid_o,
  output fwr_pkg::entry_t           entry_o
);

  logic            valid_q, valid_d;
  fwr_pkg::entry_t entry_q, entry_d;
  logic            match;

  assign match = valid_q && (entry_q.id == ctrl_i.key);
  assign hit_o = hit_i || match;
  assign sel_o = hit_i ? sel_i : entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    priority if (ctrl_i.remove && hit_o) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (ctrl_i.push && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      entry_d = ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- rtl/core/fifo_with_remove_by_id.sv -----
// ----------------------------------------------------------------------------
// fifo_with_remove_by_id: bounded process queue with delete by id
// Push appends at the tail, pop returns the head, delete removes the oldest
// entry with a matching id and closes the gap.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request (operation, priority_in, id_in, runtime_in);
//   rsp_o returns exactly one result per request, in request order.
//   Entries live in a row of DEPTH cells, head in cell 0. Every cell
//   compares its id with the key in the same cycle; a first-match flag
//   ripples down the row and the matched cell and all behind it take the
//   data of their successor, so pop and delete both update the row at the edge that accepts the request.
//   The result is registered and appears in the cycle after the request.
//   Throughput: one request per cycle unless the receiver stalls; the
//   path through the DEPTH id compares and the match ripple sets the clock.
//   Reset empties the queue (valid bits cleared) and drops any pending
//   result. When the receiver stalls, the result is held in the output
//   register and a new request is taken only in a cycle in which that
//   result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_remove_by_id #(
  parameter int unsigned DEPTH = fwr_pkg::DefaultDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fwr_req_if.sink     req_i,
  fwr_rsp_if.source   rsp_o
);

  logic                 accept;
  logic                 is_push, is_pop, is_del;
  logic                 full, found;
  fwr_pkg::cell_ctrl_t  ctrl;
  fwr_pkg::entry_t      wdata;
  fwr_pkg::entry_t      got;

  logic                 valid_w [DEPTH];
  fwr_pkg::entry_t      entry_w [DEPTH];
  logic                 hit_w   [DEPTH+1];
  fwr_pkg::entry_t      sel_w   [DEPTH+1];

  logic                          out_valid_q;
  logic [fwr_pkg::StatusWidth-1:0] status_q, status_d;
  fwr_pkg::entry_t               data_q, data_d;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign is_push = (req_i.operation == fwr_pkg::OP_PUSH);
  assign is_pop  = (req_i.operation == fwr_pkg::OP_POP);
  assign is_del  = (req_i.operation == fwr_pkg::OP_DELETE);

  assign full  = valid_w[DEPTH-1];
  assign found = is_pop ? valid_w[0] : hit_w[DEPTH];

  assign wdata.priority_val = req_i.priority_in;
  assign wdata.id           = req_i.id_in;
  assign wdata.runtime      = req_i.runtime_in;

  assign ctrl.push   = accept && is_push && !full;
  assign ctrl.remove = accept && (is_pop || is_del) && found;
  assign ctrl.key    = req_i.id_in;
  assign ctrl.wdata  = wdata;

  assign hit_w[0] = is_pop;
  assign sel_w[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            prev_valid;
    logic            next_valid;
    fwr_pkg::entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_entry = entry_w[i+1];
    end

    fwr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .hit_i        (hit_w[i]),
      .sel_i        (sel_w[i]),
      .hit_o        (hit_w[i+1]),
      .sel_o        (sel_w[i+1]),
      .valid_o      (valid_w[i]),
      .entry_o      (entry_w[i])
    );
  end

  assign got = is_pop ? entry_w[0] : sel_w[DEPTH];

  always_comb begin
    status_d = fwr_pkg::ST_DONE;
    data_d   = '0;
    if (is_push) begin
      if (full) begin
        status_d = fwr_pkg::ST_FULL;
      end
    end else if (is_pop || is_del) begin
      if (found) begin
        data_d = got;
      end else begin
        status_d = fwr_pkg::ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.priority_out = data_q.priority_val;
  assign rsp_o.id_out       = data_q.id;
  assign rsp_o.runtime_out  = data_q.runtime;

endmodule

`default_nettype wire
